// File: hw/rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and codes of the i2c master transfer sequencer
// Command codes, decoded item kinds, transfer modes and queue payloads.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // command codes on the input channel
  localparam logic [2:0] CMD_LOAD_TX    = 3'd0;
  localparam logic [2:0] CMD_START_WR   = 3'd1;
  localparam logic [2:0] CMD_START_RD   = 3'd2;
  localparam logic [2:0] CMD_START_SENT = 3'd3;
  localparam logic [2:0] CMD_ADDR_ACK   = 3'd4;
  localparam logic [2:0] CMD_TX_EMPTY   = 3'd5;
  localparam logic [2:0] CMD_RX_BYTE    = 3'd6;

  // depths of the command queue and the result queue (powers of two)
  localparam int CQ_DEPTH  = 4;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [2:0] {
    K_NOP,
    K_LOAD,
    K_START_WR,
    K_START_RD,
    K_START_SENT,
    K_ADDR_ACK,
    K_TX_EMPTY,
    K_RX_BYTE
  } cmd_kind_t;

  typedef enum logic [2:0] {
    MODE_READY   = 3'd0,
    MODE_BUSY_TX = 3'd1,
    MODE_BUSY_RX = 3'd2,
    MODE_TX_DONE = 3'd3,
    MODE_RX_DONE = 3'd4
  } mode_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
    logic [7:0] buffer_index;
    logic [6:0] target_address;
    logic [7:0] transfer_length;
  } cmd_item_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_byte;
    logic       ack_enable;
    logic       stop_request;
    logic       start_request;
    logic       events_enabled;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic [2:0] status;
    logic       done_pulse;
    logic       start_refused;
  } res_t;

endpackage

// File: hw/rtl/i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer: byte-level i2c master sequencer
// A result passes the stage-1 register and the result queue to the out_ ports.
// Throughput: one item per cycle while the result queue has room, set by the
// single execute stage and the one-read, one-write port of the transmit store.
// Reset: synchronous, clears transfer state and both queues; the transmit
// store keeps its contents and reads of unloaded entries are undefined.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
  import i2cms_pkg::*;
#(
  parameter int TX_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [2:0] in_command,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_buffer_index,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_transfer_length,
  output logic       empty,
  input  logic       pop,
  output logic       out_write_valid,
  output logic [7:0] out_write_byte,
  output logic       out_ack_enable,
  output logic       out_stop_request,
  output logic       out_start_request,
  output logic       out_events_enabled,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_byte,
  output logic [7:0] out_rx_index,
  output logic [2:0] out_status,
  output logic       out_done_pulse,
  output logic       out_start_refused
);

  cmd_item_t head;
  logic      head_empty;
  logic      head_pop;
  res_t      res_head;

  i2cms_front #(
    .TX_DEPTH (TX_DEPTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .in_buffer_index    (in_buffer_index),
    .in_target_address  (in_target_address),
    .in_transfer_length (in_transfer_length),
    .head               (head),
    .head_empty         (head_empty),
    .head_pop           (head_pop)
  );

  i2cms_back #(
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_empty (head_empty),
    .head_pop   (head_pop),
    .res_head   (res_head),
    .res_empty  (empty),
    .res_pop    (pop)
  );

  assign out_write_valid    = res_head.write_valid;
  assign out_write_byte     = res_head.write_byte;
  assign out_ack_enable     = res_head.ack_enable;
  assign out_stop_request   = res_head.stop_request;
  assign out_start_request  = res_head.start_request;
  assign out_events_enabled = res_head.events_enabled;
  assign out_rx_valid       = res_head.rx_valid;
  assign out_rx_byte        = res_head.rx_byte;
  assign out_rx_index       = res_head.rx_index;
  assign out_status         = res_head.status;
  assign out_done_pulse     = res_head.done_pulse;
  assign out_start_refused  = res_head.start_refused;

  // a completed transfer always lands in one of the done modes
  a_done_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_done_pulse) |->
      (out_status == MODE_TX_DONE || out_status == MODE_RX_DONE))
    else $error("done without done mode");

  // a refused start only happens while a transfer is running
  a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_start_refused) |->
      (out_status == MODE_BUSY_TX || out_status == MODE_BUSY_RX))
    else $error("start refused while idle");

  // a single item never both writes a byte and delivers one
  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_write_valid && out_rx_valid))
    else $error("write and receive in one item");

  // no item is executed from an empty command queue
  a_issue_src: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> !head_empty)
    else $error("issue from empty command queue");

endmodule

// File: hw/rtl/i2cms_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_fifo: small synchronous queue
// Register-based first-in first-out queue with fill count; depth a power of two.
// ----------------------------------------------------------------------------
module i2cms_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: hw/rtl/i2cms_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_front: command intake
// Accepts items, decodes the command into a kind and queues it for the back end.
// ----------------------------------------------------------------------------
module i2cms_front
  import i2cms_pkg::*;
#(
  parameter int TX_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [2:0] in_command,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_buffer_index,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_transfer_length,
  output cmd_item_t  head,
  output logic       head_empty,
  input  logic       head_pop
);

  localparam logic [8:0] DEPTH_LIM = 9'(TX_DEPTH);

  cmd_item_t                  item;
  logic [$bits(cmd_item_t)-1:0] q_dout;
  logic                       idx_ok;

  assign idx_ok = ({1'b0, in_buffer_index} < DEPTH_LIM);

  always_comb begin
    item.data_byte       = in_data_byte;
    item.buffer_index    = in_buffer_index;
    item.target_address  = in_target_address;
    item.transfer_length = in_transfer_length;
    case (in_command)
      CMD_LOAD_TX:    item.kind = idx_ok ? K_LOAD : K_NOP;
      CMD_START_WR:   item.kind = K_START_WR;
      CMD_START_RD:   item.kind = K_START_RD;
      CMD_START_SENT: item.kind = K_START_SENT;
      CMD_ADDR_ACK:   item.kind = K_ADDR_ACK;
      CMD_TX_EMPTY:   item.kind = K_TX_EMPTY;
      CMD_RX_BYTE:    item.kind = K_RX_BYTE;
      default:        item.kind = K_NOP;
    endcase
  end

  i2cms_fifo #(
    .WIDTH ($bits(cmd_item_t)),
    .DEPTH (CQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (item),
    .pop   (head_pop),
    .dout  (q_dout),
    .full  (full),
    .empty (head_empty),
    .count ()
  );

  assign head = cmd_item_t'(q_dout);

endmodule

// File: hw/rtl/i2cms_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_back: transfer execution
// Holds the transfer state and transmit store, executes queued items and
// queues one result per item.
// ----------------------------------------------------------------------------
module i2cms_back
  import i2cms_pkg::*;
#(
  parameter int TX_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_item_t head,
  input  logic      head_empty,
  output logic      head_pop,
  output res_t      res_head,
  output logic      res_empty,
  input  logic      res_pop
);

  localparam int         AW        = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int         OCW       = $clog2(OUT_DEPTH) + 1;
  localparam logic [8:0] DEPTH_LIM = 9'(TX_DEPTH);

  mode_t      mode_r, mode_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] tx_pos_r, tx_pos_nxt;
  logic [7:0] rx_pos_r, rx_pos_nxt;
  logic       ack_r, ack_nxt;
  logic       evt_r, evt_nxt;

  logic [7:0] tx_mem_r [TX_DEPTH];
  logic [7:0] mem_rdata_r;

  logic       s1_valid_r;
  res_t       s1_res_r;
  logic       s1_mem_r;

  res_t       res;
  logic       use_mem;
  logic       busy;
  logic       issue;
  logic [OCW-1:0] out_cnt;
  logic       out_full;
  res_t       push_res;
  logic [$bits(res_t)-1:0] out_dout;

  // issue only when the result queue has room for everything in flight
  assign issue    = !head_empty && ((out_cnt + OCW'(s1_valid_r)) < OCW'(OUT_DEPTH));
  assign head_pop = issue;
  assign busy     = (mode_r == MODE_BUSY_TX) || (mode_r == MODE_BUSY_RX);

  always_comb begin
    mode_nxt   = mode_r;
    addr_nxt   = addr_r;
    left_nxt   = left_r;
    tx_pos_nxt = tx_pos_r;
    rx_pos_nxt = rx_pos_r;
    ack_nxt    = ack_r;
    evt_nxt    = evt_r;
    use_mem    = 1'b0;
    res        = '0;

    case (head.kind)
      K_START_WR, K_START_RD: begin
        if (busy) begin
          res.start_refused = 1'b1;
        end else begin
          addr_nxt          = head.target_address;
          left_nxt          = head.transfer_length;
          tx_pos_nxt        = '0;
          rx_pos_nxt        = '0;
          evt_nxt           = 1'b1;
          res.start_request = 1'b1;
          if (head.kind == K_START_WR) begin
            mode_nxt = MODE_BUSY_TX;
          end else begin
            mode_nxt = MODE_BUSY_RX;
            ack_nxt  = 1'b1;
          end
        end
      end
      K_START_SENT: begin
        if (busy) begin
          res.write_valid = 1'b1;
          res.write_byte  = {addr_r, (mode_r == MODE_BUSY_RX)};
        end
      end
      K_ADDR_ACK: begin
        // single-byte read: nack and stop right after the address
        if (mode_r == MODE_BUSY_RX && left_r == 8'd1) begin
          ack_nxt          = 1'b0;
          res.stop_request = 1'b1;
        end
      end
      K_TX_EMPTY: begin
        if (mode_r == MODE_BUSY_TX) begin
          if (left_r != '0) begin
            res.write_valid = 1'b1;
            use_mem         = ({1'b0, tx_pos_r} < DEPTH_LIM);
            tx_pos_nxt      = tx_pos_r + 8'd1;
            left_nxt        = left_r - 8'd1;
          end else begin
            res.stop_request = 1'b1;
            res.done_pulse   = 1'b1;
            evt_nxt          = 1'b0;
            mode_nxt         = MODE_TX_DONE;
          end
        end
      end
      K_RX_BYTE: begin
        if (mode_r == MODE_BUSY_RX && left_r != '0) begin
          if (left_r == 8'd2) begin
            ack_nxt          = 1'b0;
            res.stop_request = 1'b1;
          end
          res.rx_valid = 1'b1;
          res.rx_byte  = head.data_byte;
          res.rx_index = rx_pos_r;
          rx_pos_nxt   = rx_pos_r + 8'd1;
          left_nxt     = left_r - 8'd1;
          if (left_r == 8'd1) begin
            mode_nxt       = MODE_RX_DONE;
            res.done_pulse = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    res.ack_enable     = ack_nxt;
    res.events_enabled = evt_nxt;
    res.status         = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_READY;
      addr_r     <= '0;
      left_r     <= '0;
      tx_pos_r   <= '0;
      rx_pos_r   <= '0;
      ack_r      <= 1'b0;
      evt_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
      if (issue) begin
        mode_r   <= mode_nxt;
        addr_r   <= addr_nxt;
        left_r   <= left_nxt;
        tx_pos_r <= tx_pos_nxt;
        rx_pos_r <= rx_pos_nxt;
        ack_r    <= ack_nxt;
        evt_r    <= evt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_res_r <= res;
      s1_mem_r <= use_mem;
    end
  end

  // transmit store: one write port for loads, one registered read for sends
  always_ff @(posedge clk) begin
    if (issue && head.kind == K_LOAD) begin
      tx_mem_r[head.buffer_index[AW-1:0]] <= head.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && use_mem) begin
      mem_rdata_r <= tx_mem_r[tx_pos_r[AW-1:0]];
    end
  end

  always_comb begin
    push_res = s1_res_r;
    if (s1_mem_r) begin
      push_res.write_byte = mem_rdata_r;
    end
  end

  i2cms_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s1_valid_r),
    .din   (push_res),
    .pop   (res_pop),
    .dout  (out_dout),
    .full  (out_full),
    .empty (res_empty),
    .count (out_cnt)
  );

  assign res_head = res_t'(out_dout);

  always_ff @(posedge clk) begin
    if (rst_n && s1_valid_r && out_full) begin
      $error("result queue overrun");
    end
  end

endmodule
